>>> src/gblur_pkg.sv
// shared constants, types and helpers of the 3x3 gaussian blur unit
// no dependencies; every other file of the block imports this package
`default_nettype none

package gblur_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_FRAC_BITS = 8;

    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 16;
    localparam int WEIGHT_W   = 8;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // input row runs one past the last line plus one while draining
    localparam int ROW_W = HEIGHT_W + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QLEVEL_W    = $clog2(QUEUE_DEPTH + 1);

    localparam int ESUM_W = CH_W + 2;
    localparam int CPROD_W = CH_W + WEIGHT_W;
    localparam int EPROD_W = ESUM_W + WEIGHT_W;
    localparam int ACC_W   = EPROD_W + 2;

    localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 11'd640;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 16'd480;
    localparam logic [WEIGHT_W-1:0] RST_CENTRE = 8'd52;
    localparam logic [WEIGHT_W-1:0] RST_EDGE   = 8'd32;
    localparam logic [WEIGHT_W-1:0] RST_CORNER = 8'd19;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_CENTRE = 3'd2,
        REG_EDGE   = 3'd3,
        REG_CORNER = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CH_W-1:0] a;
        logic [CH_W-1:0] b;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] r;
    } t_pix;

    localparam int PIX_W = $bits(t_pix);

    // one blur job: per-channel centre value and sums of side and diagonal taps, plus alpha and end flags
    typedef struct packed {
        logic [NUM_CH-1:0][CH_W-1:0]   centre;
        logic [NUM_CH-1:0][ESUM_W-1:0] edges;
        logic [NUM_CH-1:0][ESUM_W-1:0] corners;
        logic [CH_W-1:0]               alpha;
        logic                          line_end;
        logic                          frame_end;
    } t_task;

    function automatic logic [CH_W-1:0] pix_ch(input t_pix p, input int unsigned ch);
        return p[CH_W*ch +: CH_W];
    endfunction

endpackage

`default_nettype wire

>>> src/gblur_front.sv
// front end: pixel counters, line store, 3x3 window and tap masking
// depends on gblur_pkg; pushes one blur job per emitted pixel into the queue
`default_nettype none

module gblur_front #(
    parameter int MAX_WIDTH = gblur_pkg::DEF_MAX_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_restart,
    input  logic [gblur_pkg::WIDTH_W-1:0]      i_width,
    input  logic [gblur_pkg::HEIGHT_W-1:0]     i_height,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_func,
    input  gblur_pkg::t_pix                    i_pix,
    input  logic [gblur_pkg::QLEVEL_W-1:0]     i_q_level,
    output logic                               o_push,
    output gblur_pkg::t_task                   o_task
);
    import gblur_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int EW = (WIDTH_W > $clog2(MAX_WIDTH + 1)) ? WIDTH_W : $clog2(MAX_WIDTH + 1);

    typedef struct packed {
        logic [AW-1:0] col;
        t_pix          px;
        logic          emit;
        logic          col_zero;
        logic          col0_ok;
        logic          col2_ok;
        logic          row0_ok;
        logic          row2_ok;
        logic          last;
    } t_stage;

    logic [EW-1:0]       eff_w;
    logic [HEIGHT_W-1:0] eff_h;
    logic [ROW_W-1:0]    h_ext;
    logic [AW-1:0]       r_col, n_col;
    logic [ROW_W-1:0]    r_row, n_row;
    logic                in_frame, col_zero, col_last, frame_last;
    logic                accept, advance;
    t_stage              st_a, r_b;
    logic                r_b_valid;

    logic [2*PIX_W-1:0]  r_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0]  r_rd_q, r_fwd_data, line_q, wr_data;
    logic                r_fwd_hit;

    t_pix                nw [3];
    t_pix                r_win [3][3];
    t_pix                win_out [3][3];
    t_pix                tap [3][3];
    logic                cok, rok;

    always_comb begin
        if (i_width == '0) begin
            eff_w = EW'(1);
        end else if (32'(i_width) > 32'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = EW'(i_width);
        end
    end

    assign eff_h = (i_height == '0) ? HEIGHT_W'(1) : i_height;
    assign h_ext = ROW_W'(eff_h);

    assign in_frame   = r_row < h_ext;
    assign col_zero   = r_col == '0;
    assign col_last   = (EW'(r_col) + EW'(1)) >= eff_w;
    // the item at column zero two rows past the last line emits the frame's last pixel
    assign frame_last = col_zero && (r_row == h_ext + ROW_W'(1));

    // credit check: the queue must hold what is in the read stage as well
    assign o_in_ready = ({1'b0, i_q_level} + (QLEVEL_W+1)'(r_b_valid))
                        < (QLEVEL_W+1)'(QUEUE_DEPTH);
    assign accept  = i_in_valid && o_in_ready;
    // a drain item that arrives before the frame is complete is dropped
    assign advance = accept && !(in_frame && i_func);

    always_comb begin
        st_a.col      = r_col;
        st_a.px       = in_frame ? i_pix : '0;
        st_a.col_zero = col_zero;
        st_a.last     = frame_last;
        st_a.col2_ok  = !col_zero;
        if (col_zero) begin
            // emits the last column of the line two rows up
            st_a.emit    = r_row >= ROW_W'(2);
            st_a.col0_ok = eff_w != EW'(1);
            st_a.row0_ok = r_row >= ROW_W'(3);
            st_a.row2_ok = r_row <= h_ext;
        end else begin
            st_a.emit    = r_row >= ROW_W'(1);
            st_a.col0_ok = r_col >= AW'(2);
            st_a.row0_ok = r_row >= ROW_W'(2);
            st_a.row2_ok = r_row < h_ext;
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (advance) begin
            if (frame_last) begin
                n_col = '0;
                n_row = '0;
            end else if (col_last) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col     <= '0;
            r_row     <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_b_valid <= advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_b        <= st_a;
            r_fwd_hit  <= r_b_valid && (r_b.col == r_col);
            r_fwd_data <= wr_data;
        end
    end

    // line store word: middle line in the upper half, upper line in the lower half
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rd_q <= r_mem[r_col];
        end
        if (r_b_valid) begin
            r_mem[r_b.col] <= wr_data;
        end
    end

    // read-after-write on the same column (one-pixel lines) takes the fresh word
    assign line_q  = r_fwd_hit ? r_fwd_data : r_rd_q;
    assign nw[0]   = line_q[PIX_W-1:0];
    assign nw[1]   = line_q[2*PIX_W-1:PIX_W];
    assign nw[2]   = r_b.px;
    assign wr_data = {r_b.px, nw[1]};

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            for (int r = 0; r < 3; r++) begin
                win_out[c][r] = r_win[c+1][r];
            end
        end
        for (int r = 0; r < 3; r++) begin
            win_out[2][r] = r_b.col_zero ? '0 : nw[r];
        end
    end

    always_comb begin
        cok = 1'b1;
        rok = 1'b1;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                cok = (c == 0) ? r_b.col0_ok : ((c == 2) ? r_b.col2_ok : 1'b1);
                rok = (r == 0) ? r_b.row0_ok : ((r == 2) ? r_b.row2_ok : 1'b1);
                tap[c][r] = (cok && rok) ? win_out[c][r] : '0;
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            o_task.centre[ch]  = pix_ch(tap[1][1], ch);
            o_task.edges[ch]   = ESUM_W'(pix_ch(tap[0][1], ch)) + ESUM_W'(pix_ch(tap[2][1], ch))
                               + ESUM_W'(pix_ch(tap[1][0], ch)) + ESUM_W'(pix_ch(tap[1][2], ch));
            o_task.corners[ch] = ESUM_W'(pix_ch(tap[0][0], ch)) + ESUM_W'(pix_ch(tap[0][2], ch))
                               + ESUM_W'(pix_ch(tap[2][0], ch)) + ESUM_W'(pix_ch(tap[2][2], ch));
        end
        o_task.alpha     = win_out[1][1].a;
        o_task.line_end  = r_b.col_zero;
        o_task.frame_end = r_b.last;
    end

    assign o_push = r_b_valid && r_b.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_win <= '{default: '0};
        end else if (r_b_valid) begin
            if (r_b.last) begin
                r_win <= '{default: '0};
            end else begin
                for (int c = 0; c < 2; c++) begin
                    for (int r = 0; r < 3; r++) begin
                        r_win[c][r] <= r_b.col_zero ? '0 : r_win[c+1][r];
                    end
                end
                for (int r = 0; r < 3; r++) begin
                    r_win[2][r] <= nw[r];
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> src/gblur_queue.sv
// short job queue between the window front end and the multiply back end
// depends on gblur_pkg for the job type and depth
`default_nettype none

module gblur_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  gblur_pkg::t_task               i_task,
    input  logic                           i_pop,
    output logic                           o_valid,
    output gblur_pkg::t_task               o_task,
    output logic [gblur_pkg::QLEVEL_W-1:0] o_level
);
    import gblur_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_task               r_buf [QUEUE_DEPTH];
    logic [PW-1:0]       r_wr, r_rd;
    logic [QLEVEL_W-1:0] r_level;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= bump(r_wr);
            end
            if (i_pop) begin
                r_rd <= bump(r_rd);
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + QLEVEL_W'(1);
            end else if (!i_push && i_pop) begin
                r_level <= r_level - QLEVEL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_task;
        end
    end

    assign o_valid = r_level != '0;
    assign o_task  = r_buf[r_rd];
    assign o_level = r_level;

endmodule

`default_nettype wire

>>> src/gblur_back.sv
// back end: weight multiply stage, then sum, shift, saturate into the output register
// depends on gblur_pkg for the job type and widths
`default_nettype none

module gblur_back #(
    parameter int WEIGHT_FRAC_BITS = gblur_pkg::DEF_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [gblur_pkg::WEIGHT_W-1:0]   i_centre_w,
    input  logic [gblur_pkg::WEIGHT_W-1:0]   i_edge_w,
    input  logic [gblur_pkg::WEIGHT_W-1:0]   i_corner_w,
    input  logic                             i_q_valid,
    input  gblur_pkg::t_task                 i_task,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [gblur_pkg::CH_W-1:0]       o_red,
    output logic [gblur_pkg::CH_W-1:0]       o_green,
    output logic [gblur_pkg::CH_W-1:0]       o_blue,
    output logic [gblur_pkg::CH_W-1:0]       o_alpha,
    output logic                             o_line_end,
    output logic                             o_frame_end
);
    import gblur_pkg::*;

    logic                r_s1_valid;
    logic [CPROD_W-1:0]  r_cp [NUM_CH];
    logic [EPROD_W-1:0]  r_ep [NUM_CH];
    logic [EPROD_W-1:0]  r_kp [NUM_CH];
    logic [CH_W-1:0]     r_s1_alpha;
    logic                r_s1_le, r_s1_fe;
    logic                s1_ready, s2_ready;

    logic [ACC_W-1:0]    acc [NUM_CH];
    logic [ACC_W-1:0]    shifted [NUM_CH];
    logic [CH_W-1:0]     sat [NUM_CH];

    logic                r_o_valid;
    logic [CH_W-1:0]     r_o_ch [NUM_CH];
    logic [CH_W-1:0]     r_o_alpha;
    logic                r_o_le, r_o_fe;

    assign s2_ready = !r_o_valid || i_out_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_pop    = i_q_valid && s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_q_valid;
            end
            if (s2_ready) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_cp[ch] <= i_task.centre[ch] * i_centre_w;
                r_ep[ch] <= i_task.edges[ch] * i_edge_w;
                r_kp[ch] <= i_task.corners[ch] * i_corner_w;
            end
            r_s1_alpha <= i_task.alpha;
            r_s1_le    <= i_task.line_end;
            r_s1_fe    <= i_task.frame_end;
        end
    end

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            acc[ch]     = ACC_W'(r_cp[ch]) + ACC_W'(r_ep[ch]) + ACC_W'(r_kp[ch]);
            shifted[ch] = acc[ch] >> WEIGHT_FRAC_BITS;
            sat[ch]     = (|shifted[ch][ACC_W-1:CH_W]) ? {CH_W{1'b1}} : shifted[ch][CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_o_ch[ch] <= sat[ch];
            end
            r_o_alpha <= r_s1_alpha;
            r_o_le    <= r_s1_le;
            r_o_fe    <= r_s1_fe;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_red       = r_o_ch[0];
    assign o_green     = r_o_ch[1];
    assign o_blue      = r_o_ch[2];
    assign o_alpha     = r_o_alpha;
    assign o_line_end  = r_o_le;
    assign o_frame_end = r_o_fe;

endmodule

`default_nettype wire

>>> src/gaussian_blur_3x3_rgb_unit.sv
// top level of the 3x3 gaussian blur unit: configuration registers and block wiring
// depends on gblur_pkg, gblur_front, gblur_queue and gblur_back
`default_nettype none

// Blurs an RGBA pixel stream in raster order with a 3x3 kernel, one pixel per clock
// sustained while o_in_ready stays high (it drops when the job queue has no credit left).
// Every accepted item (pixel or drain step) makes a single line store read, and the result
// of an emitting item passes the read stage, the job queue and the multiply stage into the
// output register. Output lags the input by one line plus one pixel; after the last
// pixel, send drain items (func = 1) until the pixel marked frame_end comes out, then the
// next frame may start. Taps outside the frame count as zero and the sum is not
// renormalized; alpha is copied from the centre. The line store is a memory of MAX_WIDTH
// words of two pixels and needs no clearing pass, since rows above the first and below
// the last line are always masked. Write the configuration only while the block is idle;
// a width or height write restarts the frame.
module gaussian_blur_3x3_rgb_unit #(
    parameter int MAX_WIDTH        = gblur_pkg::DEF_MAX_WIDTH,
    parameter int WEIGHT_FRAC_BITS = gblur_pkg::DEF_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gblur_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gblur_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_func,
    input  logic [gblur_pkg::CH_W-1:0]         i_red_in,
    input  logic [gblur_pkg::CH_W-1:0]         i_green_in,
    input  logic [gblur_pkg::CH_W-1:0]         i_blue_in,
    input  logic [gblur_pkg::CH_W-1:0]         i_alpha_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [gblur_pkg::CH_W-1:0]         o_red_out,
    output logic [gblur_pkg::CH_W-1:0]         o_green_out,
    output logic [gblur_pkg::CH_W-1:0]         o_blue_out,
    output logic [gblur_pkg::CH_W-1:0]         o_alpha_out,
    output logic                               o_line_end,
    output logic                               o_frame_end
);
    import gblur_pkg::*;

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [WEIGHT_W-1:0] r_centre_w, r_edge_w, r_corner_w;
    logic                restart;

    t_pix                in_pix;
    logic                push, pop, q_valid;
    t_task               push_task, pop_task;
    logic [QLEVEL_W-1:0] q_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= RST_WIDTH;
            r_height   <= RST_HEIGHT;
            r_centre_w <= RST_CENTRE;
            r_edge_w   <= RST_EDGE;
            r_corner_w <= RST_CORNER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH:  r_width    <= i_cfg_data[WIDTH_W-1:0];
                REG_HEIGHT: r_height   <= i_cfg_data[HEIGHT_W-1:0];
                REG_CENTRE: r_centre_w <= i_cfg_data[WEIGHT_W-1:0];
                REG_EDGE:   r_edge_w   <= i_cfg_data[WEIGHT_W-1:0];
                REG_CORNER: r_corner_w <= i_cfg_data[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    assign restart = i_cfg_we && ((i_cfg_idx == REG_WIDTH) || (i_cfg_idx == REG_HEIGHT));

    assign in_pix = '{a: i_alpha_in, b: i_blue_in, g: i_green_in, r: i_red_in};

    gblur_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (restart),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_func     (i_func),
        .i_pix      (in_pix),
        .i_q_level  (q_level),
        .o_push     (push),
        .o_task     (push_task)
    );

    gblur_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_task  (push_task),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_task  (pop_task),
        .o_level (q_level)
    );

    gblur_back #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_centre_w  (r_centre_w),
        .i_edge_w    (r_edge_w),
        .i_corner_w  (r_corner_w),
        .i_q_valid   (q_valid),
        .i_task      (pop_task),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_red       (o_red_out),
        .o_green     (o_green_out),
        .o_blue      (o_blue_out),
        .o_alpha     (o_alpha_out),
        .o_line_end  (o_line_end),
        .o_frame_end (o_frame_end)
    );

endmodule

`default_nettype wire

>>> src/gblur_checker.sv
// port-level checks of the blur unit's output channel, bound to the top level
// depends on gblur_pkg for field widths and on gaussian_blur_3x3_rgb_unit
`default_nettype none

module gblur_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         o_out_valid,
    input  logic                         i_out_ready,
    input  logic [gblur_pkg::CH_W-1:0]   o_red_out,
    input  logic [gblur_pkg::CH_W-1:0]   o_green_out,
    input  logic [gblur_pkg::CH_W-1:0]   o_blue_out,
    input  logic [gblur_pkg::CH_W-1:0]   o_alpha_out,
    input  logic                         o_line_end,
    input  logic                         o_frame_end
);
    import gblur_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable({o_red_out, o_green_out, o_blue_out,
                                                  o_alpha_out, o_line_end, o_frame_end}))
        else $error("output payload changed while stalled");

    // the last pixel of a frame is also the last of its line
    a_frame_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_end |-> o_line_end)
        else $error("frame end without line end");

    // nothing is offered in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind gaussian_blur_3x3_rgb_unit gblur_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_red_out   (o_red_out),
    .o_green_out (o_green_out),
    .o_blue_out  (o_blue_out),
    .o_alpha_out (o_alpha_out),
    .o_line_end  (o_line_end),
    .o_frame_end (o_frame_end)
);

`default_nettype wire
